// ===== hdl/lsas_pkg.sv =====
// Shared types and constants for the scan-halves steering block.
// No dependencies; imported by every module of the block.
package lsas_pkg;

   localparam int RANGE_W = 16;
   localparam int COUNT_W = 13;
   localparam int LIN_W   = 18;
   localparam int ANG_W   = 19;
   localparam int TURN_W  = 15;
   localparam int PROD_W  = 37;

   localparam logic [COUNT_W-1:0] POINT_COUNT_RST = 13'd720;
   localparam logic [RANGE_W-1:0] CEILING_RST     = 16'hFFFF;

   localparam logic [0:0] CSR_POINT_COUNT = 1'b0;
   localparam logic [0:0] CSR_CEILING     = 1'b1;

   localparam logic [22:0]              GAIN_K     = 23'd75;
   localparam logic [22:0]              GAIN_KNEE  = 23'd100000;
   localparam logic signed [LIN_W-1:0]  GAIN_OFS   = 18'sd50000;
   localparam logic signed [LIN_W-1:0]  GAIN_CAP   = 18'sd50000;
   localparam logic signed [LIN_W-1:0]  TURN_LIM   = 18'sd10000;
   localparam logic signed [21:0]       ANG_K      = -22'sd1143836;
   localparam logic signed [PROD_W-1:0] ANG_ROUND  = 37'sd32768;

   typedef struct packed {
      logic [RANGE_W-1:0] left;
      logic [RANGE_W-1:0] right;
   } mins_type;

endpackage

// ===== hdl/lsas_scan.sv =====
// Scan tracker: point counter and running left and right minimums.
// Depends on lsas_pkg; feeds finished scans to lsas_steer.
module lsas_scan #(
   parameter int MAX_POINTS = 4096
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [lsas_pkg::COUNT_W-1:0]  point_count,
   input  logic [lsas_pkg::RANGE_W-1:0]  ceiling_mm,
   input  logic                          accept,
   input  logic [lsas_pkg::RANGE_W-1:0]  range_mm,
   output logic                          done,
   output lsas_pkg::mins_type            mins
);
   import lsas_pkg::*;

   localparam int IDX_W = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
   localparam int CNT_W = $clog2(MAX_POINTS + 1);
   localparam int CMP_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
   localparam logic [CMP_W-1:0] MAX_WIDE = CMP_W'(MAX_POINTS);

   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [RANGE_W-1:0] left_ff, left_in;
   logic [RANGE_W-1:0] right_ff, right_in;

   logic [CMP_W-1:0]   count_wide;
   logic [CNT_W-1:0]   n_eff;
   logic [CNT_W-1:0]   idx_wide;
   logic               is_left;
   logic               last;
   logic [RANGE_W-1:0] base_l, base_r, new_l, new_r;

   always_comb begin
      count_wide = CMP_W'(point_count);
      if (count_wide == '0) begin
         n_eff = CNT_W'(1);
      end else if (count_wide > MAX_WIDE) begin
         n_eff = CNT_W'(MAX_POINTS);
      end else begin
         n_eff = count_wide[CNT_W-1:0];
      end
      idx_wide = CNT_W'(idx_ff);
      is_left  = idx_wide < (n_eff >> 1);
      last     = (idx_wide + CNT_W'(1)) >= n_eff;

      base_l = (idx_ff == '0) ? ceiling_mm : left_ff;
      base_r = (idx_ff == '0) ? ceiling_mm : right_ff;
      new_l  = base_l;
      new_r  = base_r;
      if (range_mm != '0) begin
         if (is_left) begin
            if (range_mm < base_l) new_l = range_mm;
         end else begin
            if (range_mm < base_r) new_r = range_mm;
         end
      end

      idx_in   = idx_ff;
      left_in  = left_ff;
      right_in = right_ff;
      if (accept) begin
         if (last) begin
            idx_in   = '0;
            left_in  = ceiling_mm;
            right_in = ceiling_mm;
         end else begin
            idx_in   = idx_ff + IDX_W'(1);
            left_in  = new_l;
            right_in = new_r;
         end
      end
   end

   assign done       = accept && last;
   assign mins.left  = new_l;
   assign mins.right = new_r;

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         left_ff  <= CEILING_RST;
         right_ff <= CEILING_RST;
      end else begin
         idx_ff   <= idx_in;
         left_ff  <= left_in;
         right_ff <= right_in;
      end
   end

endmodule

// ===== hdl/lsas_steer.sv =====
// Steering pipeline: gains and turn clamp, then turn-rate multiply, then result register.
// Depends on lsas_pkg; fed by lsas_scan.
module lsas_steer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   input  lsas_pkg::mins_type                  in_mins,
   output logic                                in_ready,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [lsas_pkg::LIN_W-1:0]   rsp_linear_um_s,
   output logic signed [lsas_pkg::ANG_W-1:0]   rsp_angular_urad_s,
   output logic [lsas_pkg::RANGE_W-1:0]        rsp_left_min_mm,
   output logic [lsas_pkg::RANGE_W-1:0]        rsp_right_min_mm
);
   import lsas_pkg::*;

   function automatic logic signed [LIN_W-1:0] gain_term(input logic [RANGE_W-1:0] mm);
      logic [22:0] p;
      begin
         p = 23'(mm) * GAIN_K;
         if (p > GAIN_KNEE) begin
            return GAIN_CAP;
         end
         return $signed({1'b0, p[16:0]}) - GAIN_OFS;
      end
   endfunction

   logic                       s2_v_ff;
   mins_type                   s2_mins_ff;
   logic                       s3_v_ff;
   mins_type                   s3_mins_ff;
   logic signed [LIN_W-1:0]    s3_lin_ff, s3_lin_in;
   logic signed [TURN_W-1:0]   s3_turn_ff, s3_turn_in;
   logic                       rsp_valid_ff;
   logic signed [LIN_W-1:0]    rsp_lin_ff;
   logic signed [ANG_W-1:0]    rsp_ang_ff, rsp_ang_in;
   mins_type                   rsp_mins_ff;

   logic                       out_ready, s3_ready, s2_ready;
   logic signed [LIN_W-1:0]    gl, gr, turn_raw;
   logic signed [PROD_W-1:0]   ang_prod, ang_sum, ang_shift;

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign s3_ready  = !s3_v_ff || out_ready;
   assign s2_ready  = !s2_v_ff || s3_ready;
   assign in_ready  = s2_ready;

   always_comb begin
      gl        = gain_term(s2_mins_ff.right);
      gr        = gain_term(s2_mins_ff.left);
      s3_lin_in = gr + gl;
      turn_raw  = gr - gl;
      if (turn_raw > TURN_LIM) begin
         s3_turn_in = TURN_W'(TURN_LIM);
      end else if (turn_raw < -TURN_LIM) begin
         s3_turn_in = TURN_W'(-TURN_LIM);
      end else begin
         s3_turn_in = turn_raw[TURN_W-1:0];
      end

      ang_prod   = s3_turn_ff * ANG_K;
      ang_sum    = ang_prod + ANG_ROUND;
      ang_shift  = ang_sum >>> 16;
      rsp_ang_in = ang_shift[ANG_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff      <= 1'b0;
         s3_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s2_ready) s2_v_ff <= in_valid;
         if (s3_ready) s3_v_ff <= s2_v_ff;
         if (out_ready) rsp_valid_ff <= s3_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready && in_valid) begin
         s2_mins_ff <= in_mins;
      end
      if (s3_ready && s2_v_ff) begin
         s3_mins_ff <= s2_mins_ff;
         s3_lin_ff  <= s3_lin_in;
         s3_turn_ff <= s3_turn_in;
      end
      if (out_ready && s3_v_ff) begin
         rsp_mins_ff <= s3_mins_ff;
         rsp_lin_ff  <= s3_lin_ff;
         rsp_ang_ff  <= rsp_ang_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_linear_um_s    = rsp_lin_ff;
   assign rsp_angular_urad_s = rsp_ang_ff;
   assign rsp_left_min_mm    = rsp_mins_ff.left;
   assign rsp_right_min_mm   = rsp_mins_ff.right;

endmodule

// ===== hdl/laser_scan_halves_avoid_steer.sv =====
// Top level of the scan-halves obstacle-avoidance steering block.
// Depends on lsas_pkg, lsas_scan and lsas_steer.
//
// Input channel (req_): one laser range per item, in millimetres; zero means
// no return and leaves both minimums alone. An item is taken on a rising edge
// with req_valid high and req_stall low. One item is taken every cycle while req_stall
// is low; the running minimum and point counter update on the edge that takes it.
// Result channel (rsp_): one item per scan, produced by the last point of the
// scan; it carries speed, turn rate and both half-scan minimums. The result
// appears on rsp_valid from the output register: the scan minimums are registered
// on the edge that takes the last point, then the gain and turn clamp, and then the
// turn-rate multiply into the output register; a receiver stall can hold each stage.
// Configuration (csr_): point count and range ceiling, written while idle;
// the range ceiling takes effect at the next scan start.
// Reset (synchronous, active high): point counter to zero, pipeline empty,
// point count to 720 and range ceiling to 65535.
// When the receiver stalls, the result holds and the pipeline fills; req_stall
// rises only once all three result stages are occupied.
module laser_scan_halves_avoid_steer #(
   parameter int MAX_POINTS = 4096
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [0:0]                         csr_index,
   input  logic [lsas_pkg::RANGE_W-1:0]       csr_wr_data,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [lsas_pkg::RANGE_W-1:0]       req_range_mm,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [lsas_pkg::LIN_W-1:0]  rsp_linear_um_s,
   output logic signed [lsas_pkg::ANG_W-1:0]  rsp_angular_urad_s,
   output logic [lsas_pkg::RANGE_W-1:0]       rsp_left_min_mm,
   output logic [lsas_pkg::RANGE_W-1:0]       rsp_right_min_mm
);
   import lsas_pkg::*;

   logic [COUNT_W-1:0] point_count_ff, point_count_in;
   logic [RANGE_W-1:0] ceiling_ff, ceiling_in;
   logic               accept;
   logic               steer_ready;
   logic               scan_done;
   mins_type           scan_mins;

   always_comb begin
      point_count_in = point_count_ff;
      ceiling_in     = ceiling_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_POINT_COUNT: point_count_in = csr_wr_data[COUNT_W-1:0];
            CSR_CEILING:     ceiling_in     = csr_wr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff <= POINT_COUNT_RST;
         ceiling_ff     <= CEILING_RST;
      end else begin
         point_count_ff <= point_count_in;
         ceiling_ff     <= ceiling_in;
      end
   end

   assign req_stall = !steer_ready;
   assign accept    = req_valid && steer_ready;

   lsas_scan #(
      .MAX_POINTS (MAX_POINTS)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .point_count (point_count_ff),
      .ceiling_mm  (ceiling_ff),
      .accept      (accept),
      .range_mm    (req_range_mm),
      .done        (scan_done),
      .mins        (scan_mins)
   );

   lsas_steer u_steer (
      .clock              (clock),
      .reset              (reset),
      .in_valid           (scan_done),
      .in_mins            (scan_mins),
      .in_ready           (steer_ready),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_linear_um_s    (rsp_linear_um_s),
      .rsp_angular_urad_s (rsp_angular_urad_s),
      .rsp_left_min_mm    (rsp_left_min_mm),
      .rsp_right_min_mm   (rsp_right_min_mm)
   );

endmodule

// ===== verif/tb.sv =====
// Self-checking bench for the scan-halves steering block: a stimulus table, then
// random scans under several idle patterns. Depends on lsas_pkg and the block.
// Predicts each steering result or takes it from the table, and checks it field by field as it arrives.
module tb;
   import lsas_pkg::*;

   localparam int MAX_SCAN    = 4096;
   localparam int PIPE_SETTLE = 8;
   localparam int HOLD_CYCLES = 300;
   localparam int PLAN_LEN    = 32;
   localparam int SEG_POINTS  = 40;
   localparam int CUT_POINTS  = 24;

   typedef struct packed {
      logic signed [LIN_W-1:0] linear;
      logic signed [ANG_W-1:0] angular;
      logic [RANGE_W-1:0]      left_mm;
      logic [RANGE_W-1:0]      right_mm;
   } steer_type;

   typedef enum bit {ROW_POINT, ROW_WRITE} row_kind_type;
   typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_type;

   typedef struct {
      row_kind_type       kind;
      logic [0:0]         sel;
      logic [RANGE_W-1:0] value;
      bit                 typed;
      steer_type          want;
   } plan_row_type;

   localparam steer_type NO_STEER = '0;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [0:0] csr_index = CSR_POINT_COUNT;
   logic [RANGE_W-1:0] csr_wr_data = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [RANGE_W-1:0] req_range_mm = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [LIN_W-1:0] rsp_linear_um_s;
   logic signed [ANG_W-1:0] rsp_angular_urad_s;
   logic [RANGE_W-1:0] rsp_left_min_mm;
   logic [RANGE_W-1:0] rsp_right_min_mm;

   logic hold_go = 1'b0;
   logic long_hold = 1'b0;
   int send_idle_pct = 0;
   int stall_pct = 0;

   int unsigned scan_len = POINT_COUNT_RST;
   logic [RANGE_W-1:0] range_ceiling = CEILING_RST;
   int unsigned pt_index = 0;
   logic [RANGE_W-1:0] left_run = CEILING_RST;
   logic [RANGE_W-1:0] right_run = CEILING_RST;

   steer_type steer_due[$];
   steer_type oldest;
   int points_sent = 0;
   int steers_seen = 0;
   int reg_writes = 0;
   int mismatches = 0;

   plan_row_type plan [PLAN_LEN] = '{
      '{ROW_POINT, CSR_POINT_COUNT, 16'h0000, 1'b0, NO_STEER},
      '{ROW_POINT, CSR_POINT_COUNT, 16'hFFFF, 1'b0, NO_STEER},
      '{ROW_POINT, CSR_POINT_COUNT, 16'h0000, 1'b0, NO_STEER},
      '{ROW_WRITE, CSR_POINT_COUNT, 16'd4,    1'b0, NO_STEER},
      '{ROW_POINT, CSR_POINT_COUNT, 16'h8000, 1'b1,
        '{18'sd100000, 19'sd0, 16'hFFFF, 16'h8000}},
      '{ROW_POINT, CSR_POINT_COUNT, 16'd1,    1'b0, NO_STEER},
      '{ROW_POINT, CSR_POINT_COUNT, 16'hFFFF, 1'b0, NO_STEER},
      '{ROW_POINT, CSR_POINT_COUNT, 16'h0000, 1'b0, NO_STEER},
      '{ROW_POINT, CSR_POINT_COUNT, 16'h0000, 1'b1,
        '{18'sd75, 19'sd174536, 16'd1, 16'hFFFF}},
      '{ROW_POINT, CSR_POINT_COUNT, 16'h0000, 1'b0, NO_STEER},
      '{ROW_POINT, CSR_POINT_COUNT, 16'h0000, 1'b0, NO_STEER},
      '{ROW_POINT, CSR_POINT_COUNT, 16'd1,    1'b0, NO_STEER},
      '{ROW_POINT, CSR_POINT_COUNT, 16'd2,    1'b1,
        '{18'sd75, -19'sd174536, 16'hFFFF, 16'd1}},
      '{ROW_WRITE, CSR_CEILING,     16'd0,    1'b0, NO_STEER},
      '{ROW_POINT, CSR_POINT_COUNT, 16'd5,    1'b0, NO_STEER},
      '{ROW_POINT, CSR_POINT_COUNT, 16'd6,    1'b0, NO_STEER},
      '{ROW_POINT, CSR_POINT_COUNT, 16'd7,    1'b0, NO_STEER},
      '{ROW_POINT, CSR_POINT_COUNT, 16'd8,    1'b1,
        '{-18'sd100000, 19'sd0, 16'd0, 16'd0}},
      '{ROW_WRITE, CSR_CEILING,     16'd1333, 1'b0, NO_STEER},
      '{ROW_WRITE, CSR_POINT_COUNT, 16'd0,    1'b0, NO_STEER},
      '{ROW_POINT, CSR_POINT_COUNT, 16'd1400, 1'b1,
        '{18'sd99950, 19'sd0, 16'd1333, 16'd1333}},
      '{ROW_POINT, CSR_POINT_COUNT, 16'd0,    1'b1,
        '{18'sd99950, 19'sd0, 16'd1333, 16'd1333}},
      '{ROW_POINT, CSR_POINT_COUNT, 16'd1,    1'b1,
        '{18'sd50, -19'sd174536, 16'd1333, 16'd1}},
      '{ROW_WRITE, CSR_POINT_COUNT, 16'd1,    1'b0, NO_STEER},
      '{ROW_POINT, CSR_POINT_COUNT, 16'd700,  1'b0, NO_STEER},
      '{ROW_WRITE, CSR_POINT_COUNT, 16'd3,    1'b0, NO_STEER},
      '{ROW_POINT, CSR_POINT_COUNT, 16'd1000, 1'b0, NO_STEER},
      '{ROW_POINT, CSR_POINT_COUNT, 16'd900,  1'b0, NO_STEER},
      '{ROW_POINT, CSR_POINT_COUNT, 16'd800,  1'b0, NO_STEER},
      '{ROW_WRITE, CSR_POINT_COUNT, 16'hE002, 1'b0, NO_STEER},
      '{ROW_POINT, CSR_POINT_COUNT, 16'd1334, 1'b0, NO_STEER},
      '{ROW_POINT, CSR_POINT_COUNT, 16'd40000, 1'b0, NO_STEER}
   };

   laser_scan_halves_avoid_steer u_top (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wr_data        (csr_wr_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_range_mm       (req_range_mm),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_linear_um_s    (rsp_linear_um_s),
      .rsp_angular_urad_s (rsp_angular_urad_s),
      .rsp_left_min_mm    (rsp_left_min_mm),
      .rsp_right_min_mm   (rsp_right_min_mm)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic longint crossed_gain(input logic [RANGE_W-1:0] mm);
      longint v;
      v = 75 * longint'(mm) - 50000;
      if (v > 50000) v = 50000;
      return v;
   endfunction

   // advance the scan by one point; returns 1 when the point closes the scan
   function automatic bit steer_from_point(input logic [RANGE_W-1:0] mm,
                                           output steer_type res);
      int unsigned n;
      longint l_term, r_term, turn, lin, ang;
      res = NO_STEER;
      n = scan_len;
      if (n < 1) n = 1;
      if (n > MAX_SCAN) n = MAX_SCAN;
      if (pt_index == 0) begin
         left_run = range_ceiling;
         right_run = range_ceiling;
      end
      if (mm != 0) begin
         if (pt_index < n / 2) begin
            if (mm < left_run) left_run = mm;
         end else if (mm < right_run) begin
            right_run = mm;
         end
      end
      if (pt_index + 1 < n) begin
         pt_index++;
         return 1'b0;
      end
      l_term = crossed_gain(right_run);
      r_term = crossed_gain(left_run);
      lin = r_term + l_term;
      turn = r_term - l_term;
      if (turn > 10000) turn = 10000;
      if (turn < -10000) turn = -10000;
      ang = (32768 - turn * 1143836) >>> 16;
      res.linear = lin[LIN_W-1:0];
      res.angular = ang[ANG_W-1:0];
      res.left_mm = left_run;
      res.right_mm = right_run;
      pt_index = 0;
      left_run = range_ceiling;
      right_run = range_ceiling;
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string field, input longint got, input longint want);
      if (mismatches < 20)
         $display("result %0d: %s is %0d, expected %0d", steers_seen, field, got, want);
      mismatches++;
   endtask

   task automatic send_range(input logic [RANGE_W-1:0] mm, input bit typed,
                             input steer_type want);
      steer_type res;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_range_mm <= mm;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      points_sent++;
      if (steer_from_point(mm, res)) steer_due.push_back(typed ? want : res);
   endtask

   task automatic write_reg(input logic [0:0] sel, input logic [RANGE_W-1:0] value);
      req_valid <= 1'b0;
      while (steer_due.size() != 0) @(posedge clock);
      repeat (PIPE_SETTLE) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= sel;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (sel == CSR_POINT_COUNT) scan_len = value[COUNT_W-1:0];
      else range_ceiling = value;
      reg_writes++;
   endtask

   task automatic run_segment(input idle_mode_type mode, input logic [RANGE_W-1:0] count,
                              input logic [RANGE_W-1:0] ceiling, input int n_points);
      logic [RANGE_W-1:0] mm;
      write_reg(CSR_POINT_COUNT, count);
      write_reg(CSR_CEILING, ceiling);
      send_idle_pct = (mode == IDLE_SEND) ? 77 : (mode == IDLE_BOTH) ? 35 : 0;
      stall_pct = (mode == IDLE_RECV) ? 77 : (mode == IDLE_BOTH) ? 35 : 0;
      repeat (n_points) begin
         case ($urandom_range(9))
            0, 1: mm = '0;
            2: mm = 16'hFFFF;
            3: mm = 16'($urandom_range(1400, 1280));
            4: mm = 16'($urandom_range(8, 1));
            default: mm = 16'($urandom);
         endcase
         send_range(mm, 1'b0, NO_STEER);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            steers_seen++;
            if (steer_due.size() == 0) begin
               report_mismatch("unexpected result", 1, 0);
            end else begin
               oldest = steer_due.pop_front();
               if (rsp_linear_um_s !== oldest.linear)
                  report_mismatch("linear_um_s", rsp_linear_um_s, oldest.linear);
               if (rsp_angular_urad_s !== oldest.angular)
                  report_mismatch("angular_urad_s", rsp_angular_urad_s, oldest.angular);
               if (rsp_left_min_mm !== oldest.left_mm)
                  report_mismatch("left_min_mm", rsp_left_min_mm, oldest.left_mm);
               if (rsp_right_min_mm !== oldest.right_mm)
                  report_mismatch("right_min_mm", rsp_right_min_mm, oldest.right_mm);
            end
         end
         rsp_stall <= long_hold || ($urandom_range(99) < stall_pct);
      end
   end

   // hold the result channel long enough for the pipeline to back up
   initial begin
      wait (hold_go);
      @(posedge clock);
      long_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      long_hold <= 1'b0;
   end

   initial begin
      #1000000;
      $display("laser_scan_halves_avoid_steer: mismatch");
      $finish;
   end

   initial begin
      logic [RANGE_W-1:0] count;
      logic [RANGE_W-1:0] ceiling;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (plan[i]) begin
         if (plan[i].kind == ROW_WRITE) write_reg(plan[i].sel, plan[i].value);
         else send_range(plan[i].value, plan[i].typed, plan[i].want);
      end
      for (int seg = 0; seg < 8; seg++) begin
         case ($urandom_range(9))
            0: count = 16'($urandom_range(1, 0));
            1, 2: count = 16'($urandom_range(40, 13));
            default: count = 16'($urandom_range(12, 2));
         endcase
         if (seg == 0) count = 16'd2;
         case ($urandom_range(9))
            0: ceiling = '0;
            1: ceiling = 16'd1;
            2, 3: ceiling = 16'hFFFF;
            4: ceiling = 16'($urandom_range(1400, 1280));
            default: ceiling = 16'($urandom);
         endcase
         run_segment(idle_mode_type'(seg % 4), count, ceiling, SEG_POINTS);
      end
      // over-range count, then cut the scan short with a small count
      run_segment(IDLE_NONE, 16'd8191, 16'($urandom), CUT_POINTS);
      write_reg(CSR_POINT_COUNT, 16'd2);
      hold_go <= 1'b1;
      repeat (40) send_range(16'($urandom), 1'b0, NO_STEER);
      req_valid <= 1'b0;
      while (steer_due.size() != 0) @(posedge clock);
      repeat (PIPE_SETTLE) @(posedge clock);
      $display("run covered %0d range points and %0d register writes, scans of 1 to 40 points",
               points_sent, reg_writes);
      $display("%0d results checked under four idle patterns, a cut-short scan and a long hold",
               steers_seen);
      if (mismatches == 0)
         $display("laser_scan_halves_avoid_steer: match");
      else
         $display("laser_scan_halves_avoid_steer: mismatch");
      $finish;
   end

endmodule
